// File: design/bal_pkg.sv
package bal_pkg;

  // Operation codes of an input item
  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_APPEND     = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REMOVE_VAL = 3'd4;
  localparam logic [2:0] OP_SEARCH     = 3'd5;

  // Status codes of a result item
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BEYOND    = 3'd4;

  localparam int unsigned DATA_W = 32;

  // What every cell of the row does in a given cycle
  typedef enum logic [4:0] {
    CELL_HOLD    = 5'b00001,
    CELL_COMPARE = 5'b00010,
    CELL_LOCATE  = 5'b00100,
    CELL_INSERT  = 5'b01000,
    CELL_REMOVE  = 5'b10000
  } cell_mode_t;

  // Command broadcast to the whole row
  typedef struct packed {
    cell_mode_t          mode;
    logic                use_match;
    logic [DATA_W-1:0]   key;
  } cell_ctrl_t;

endpackage

// File: design/bal_cell.sv
module bal_cell #(
  parameter int IDX = 0,
  parameter int PW  = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bal_pkg::cell_ctrl_t       ctrl,
  input  logic [PW-1:0]             pos,
  input  logic [PW-1:0]             count,
  input  logic [bal_pkg::DATA_W-1:0] lower_data,
  input  logic [bal_pkg::DATA_W-1:0] upper_data,
  input  logic                      seen_in,
  input  logic                      ge_lower,
  output logic [bal_pkg::DATA_W-1:0] data,
  output logic                      seen_out,
  output logic                      first,
  output logic                      ge,
  output logic                      at
);
  import bal_pkg::*;

  logic match_q;
  logic ge_q;

  // Pass the first-match chain on and mark the target slot
  always_comb begin
    seen_out = seen_in | match_q;
    first    = match_q & ~seen_in;
    at       = ge_q & ~ge_lower;
    ge       = ge_q;
  end

  // Compare against the key and note whether this slot is at or above the target
  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      CELL_COMPARE: match_q <= (data == ctrl.key) && (PW'(IDX) < count);
      CELL_LOCATE:  ge_q    <= ctrl.use_match ? seen_out : (PW'(IDX) >= pos);
      CELL_HOLD, CELL_INSERT, CELL_REMOVE: begin
        match_q <= match_q;
        ge_q    <= ge_q;
      end
    endcase
  end

  // Hold the slot, load the key, or take a neighbour's word
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      unique case (ctrl.mode)
        CELL_INSERT: begin
          if (at) begin
            data <= ctrl.key;
          end else if (ge_q) begin
            data <= lower_data;
          end
        end
        CELL_REMOVE: begin
          if (ge_q) begin
            data <= upper_data;
          end
        end
        CELL_HOLD, CELL_COMPARE, CELL_LOCATE: data <= data;
      endcase
    end
  end

endmodule

// File: design/bounded_array_list_engine.sv
// Ordered list of signed 32-bit words held in a row of CAPACITY cells, one
// word per cell, with an element count. Each item runs through a fixed
// sequence: accept, compare (every cell checks its word against the key),
// locate (a first-match chain runs along the row and each cell learns
// whether it sits at or above the target slot), apply (the row shifts up or
// down by one and the result is registered). The next item can be accepted
// in the cycle in which that result is first offered, but not before: no new
// item is taken while the one in hand is still in compare, locate or apply.
// An item that reaches apply while the previous result still waits on
// out_stall holds there until that result is taken. Slots above the count
// always hold zero; reset clears the row at once, so no clearing pass
// follows reset.
module bounded_array_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  input  logic [5:0]         block_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] removed_value,
  output logic [4:0]         found_index,
  output logic [5:0]         element_total
);
  import bal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_COMPARE = 4'b0010,
    S_LOCATE  = 4'b0100,
    S_APPLY   = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [2:0]        op_q;
  logic [DATA_W-1:0] key_q;
  logic [5:0]        block_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              found_q;
  logic [IW-1:0]     found_idx_q;
  logic [IW-1:0]     found_idx_c;

  cell_ctrl_t        ctrl;
  logic [PW-1:0]     tgt_pos;
  logic              apply_go;
  logic [2:0]        status_c;
  logic [DATA_W-1:0] removed_c;
  logic [DATA_W-1:0] taken_c;
  logic              is_full;
  logic              is_empty;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic              cell_first [CAPACITY];
  logic              cell_ge [CAPACITY];
  logic              cell_at [CAPACITY];
  logic              seen [CAPACITY+1];

  assign in_stall = (state != S_IDLE);
  assign apply_go = (state == S_APPLY) && (!out_valid || !out_stall);
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  // Target slot for the positional operations
  always_comb begin
    unique case (op_q)
      OP_INSERT:   tgt_pos = PW'(block_q);
      OP_APPEND:   tgt_pos = PW'(count);
      OP_POP_BACK: tgt_pos = PW'(count - CW'(1));
      default:     tgt_pos = '0;
    endcase
  end

  // Decide status, row action and new count for the item in hand
  always_comb begin
    status_c   = ST_OK;
    count_next = count;
    ctrl.mode  = CELL_HOLD;
    removed_c  = '0;
    unique case (op_q)
      OP_INSERT: begin
        if (is_full) begin
          status_c = ST_FULL;
        end else if (PW'(block_q) > PW'(count)) begin
          status_c = ST_BEYOND;
        end else begin
          ctrl.mode  = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      OP_APPEND: begin
        if (is_full) begin
          status_c = ST_FULL;
        end else begin
          ctrl.mode  = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (is_empty) begin
          status_c = ST_EMPTY;
        end else begin
          ctrl.mode  = CELL_REMOVE;
          removed_c  = taken_c;
          count_next = count - CW'(1);
        end
      end
      OP_REMOVE_VAL: begin
        if (is_empty) begin
          status_c = ST_EMPTY;
        end else if (!found_q) begin
          status_c = ST_NOT_FOUND;
        end else begin
          ctrl.mode  = CELL_REMOVE;
          removed_c  = taken_c;
          count_next = count - CW'(1);
        end
      end
      OP_SEARCH: begin
        if (!found_q) begin
          status_c = ST_NOT_FOUND;
        end
      end
      default: status_c = ST_OK;
    endcase
    // Only the sequencer phase lets the row act
    unique case (state)
      S_COMPARE: ctrl.mode = CELL_COMPARE;
      S_LOCATE:  ctrl.mode = CELL_LOCATE;
      S_APPLY:   ctrl.mode = apply_go ? ctrl.mode : CELL_HOLD;
      S_IDLE:    ctrl.mode = CELL_HOLD;
    endcase
    ctrl.use_match = (op_q == OP_REMOVE_VAL);
    ctrl.key       = key_q;
  end

  // Row of cells, chained by neighbour data and the match chain
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bal_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .pos        (tgt_pos),
      .count      (PW'(count)),
      .lower_data ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i-1]),
      .upper_data ((i == CAPACITY-1) ? '0 : cell_data[(i == CAPACITY-1) ? i : i+1]),
      .seen_in    (seen[i]),
      .ge_lower   ((i == 0) ? 1'b0 : cell_ge[(i == 0) ? 0 : i-1]),
      .data       (cell_data[i]),
      .seen_out   (seen[i+1]),
      .first      (cell_first[i]),
      .ge         (cell_ge[i]),
      .at         (cell_at[i])
    );
  end

  // Gather the first-match index and the word at the target slot
  always_comb begin
    found_idx_c = '0;
    taken_c     = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_idx_c = found_idx_c | (cell_first[i] ? IW'(i) : '0);
      taken_c     = taken_c | (cell_at[i] ? cell_data[i] : '0);
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_COMPARE;
      S_COMPARE: state_next = S_LOCATE;
      S_LOCATE:  state_next = S_APPLY;
      S_APPLY:   if (apply_go) state_next = S_IDLE;
    endcase
  end

  // Control state: sequencer, count and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the item, the match result and the outgoing result
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      op_q    <= operation;
      key_q   <= value;
      block_q <= block_index;
    end
    if (state == S_LOCATE) begin
      found_q     <= seen[CAPACITY];
      found_idx_q <= found_idx_c;
    end
    if (apply_go) begin
      status        <= status_c;
      removed_value <= removed_c;
      found_index   <= ((status_c == ST_OK) &&
                        ((op_q == OP_REMOVE_VAL) || (op_q == OP_SEARCH))) ?
                       5'(found_idx_q) : '0;
      element_total <= 6'(count_next);
    end
  end

endmodule
